// File: rtl/assert_macros.svh
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// A condition that, once seen, must be followed by another in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/msrr_pkg.sv
// Types, constants and the CRC step for the sensor reply receiver.
package msrr_pkg;

    // Elapsed-time counter width.
    localparam int unsigned TIMER_BITS = 16;
    localparam int unsigned CMP_BITS   = 33;

    // Frame layout.
    localparam logic [3:0] FRAME_BYTES   = 4'd9;
    localparam logic [3:0] CRC_BYTES     = 4'd7;
    localparam logic [3:0] PAYLOAD_FIRST = 4'd3;
    localparam int unsigned PAYLOAD_DEPTH = 6;

    // CRC-16/MODBUS.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Configuration registers and their reset values.
    localparam logic CFG_CHAR_GAP   = 1'b0;
    localparam logic CFG_REPLY_WAIT = 1'b1;
    localparam logic [15:0] CHAR_GAP_RESET   = 16'd2604;
    localparam logic [15:0] REPLY_WAIT_RESET = 16'd50000;

    // Input item kinds.
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NORESP     = 2'd1;
    localparam logic [1:0] ST_INCOMPLETE = 2'd2;
    localparam logic [1:0] ST_CRC        = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_RECV = 2'd2
    } phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
        logic       read_mode;
    } in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        light_hundredths;
        logic signed [15:0] temperature_tenths;
        logic [15:0]        humidity_tenths;
        logic               reply_mode;
    } out_t;

    // Fold one byte into the running CRC, one bit per step.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/modbus_sensor_reply_receiver_top.sv
// Modbus RTU sensor reply receiver: framing, CRC check, timeouts and result.
//
//  Channel | Direction | Handshake              | Beat
//  in      | input     | in_valid / in_stall    | msrr_pkg::in_t
//  out     | output    | out_valid / out_stall  | msrr_pkg::out_t
//  cfg     | input     | cfg_we                 | cfg_index, cfg_data
//
// Every input beat is processed in the cycle it is accepted; its result, if any, is
// registered in the result register or skid. One beat can be taken every cycle while in_stall is low.
// The CRC step over one byte is the longest path between registers.
// A two-entry output stage (result register plus skid) lets one more result in
// while a result is stalled; in_stall rises only when both entries are full.
// rst_n clears the control state and sets the timeouts to 2604 and 50000 ticks.
`include "assert_macros.svh"

module modbus_sensor_reply_receiver_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  msrr_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output msrr_pkg::out_t  out_data,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [15:0]     cfg_data
);

    localparam logic [msrr_pkg::TIMER_BITS-1:0] TIMER_MAX = '1;

    // Configuration registers.
    logic [15:0] char_gap_reg;
    logic [15:0] reply_wait_reg;

    // Transaction state.
    msrr_pkg::phase_t                phase_reg, phase_next;
    logic [3:0]                      bytes_seen_reg, bytes_seen_next;
    logic [15:0]                     crc_reg, crc_next;
    logic [msrr_pkg::TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic                            mode_reg, mode_next;
    logic [7:0]                      payload_reg [msrr_pkg::PAYLOAD_DEPTH];

    // Output stage.
    logic           out_valid_reg, out_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    msrr_pkg::out_t out_data_reg;
    msrr_pkg::out_t skid_data_reg;

    logic           in_accept;
    logic           pay_we;
    logic [2:0]     pay_idx;
    logic           res_valid;
    logic [1:0]     res_status;
    msrr_pkg::out_t res_data;
    logic           res_fire;
    logic           out_load_new;
    logic           out_load_skid;
    logic           skid_load;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_gap_reg   <= msrr_pkg::CHAR_GAP_RESET;
            reply_wait_reg <= msrr_pkg::REPLY_WAIT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == msrr_pkg::CFG_CHAR_GAP)
            begin
                char_gap_reg <= cfg_data;
            end
            else
            begin
                reply_wait_reg <= cfg_data;
            end
        end
    end

    // Next transaction state and the end-of-transaction decision.
    always_comb
    begin
        logic [15:0]                     crc_step;
        logic [msrr_pkg::TIMER_BITS-1:0] elapsed_inc;
        logic [15:0]                     crc_got;
        crc_step    = msrr_pkg::crc_byte(crc_reg, in_data.rx_byte);
        elapsed_inc = (elapsed_reg < TIMER_MAX) ? elapsed_reg + 1'b1 : elapsed_reg;
        crc_got     = {in_data.rx_byte, payload_reg[4]};

        phase_next      = phase_reg;
        bytes_seen_next = bytes_seen_reg;
        crc_next        = crc_reg;
        elapsed_next    = elapsed_reg;
        mode_next       = mode_reg;
        pay_we          = 1'b0;
        pay_idx         = 3'(bytes_seen_reg - msrr_pkg::PAYLOAD_FIRST);
        res_valid       = 1'b0;
        res_status      = msrr_pkg::ST_OK;

        if (in_accept)
        begin
            unique case (in_data.kind)
                msrr_pkg::KIND_START:
                begin
                    phase_next      = msrr_pkg::PH_WAIT;
                    bytes_seen_next = '0;
                    crc_next        = msrr_pkg::CRC_INIT;
                    elapsed_next    = '0;
                    mode_next       = in_data.read_mode;
                end
                msrr_pkg::KIND_BYTE:
                begin
                    if (phase_reg != msrr_pkg::PH_IDLE)
                    begin
                        if (bytes_seen_reg < msrr_pkg::CRC_BYTES)
                        begin
                            crc_next = crc_step;
                        end
                        pay_we = (bytes_seen_reg >= msrr_pkg::PAYLOAD_FIRST)
                              && (bytes_seen_reg < msrr_pkg::FRAME_BYTES);
                        bytes_seen_next = bytes_seen_reg + 4'd1;
                        elapsed_next    = '0;
                        phase_next      = msrr_pkg::PH_RECV;
                        if (bytes_seen_next >= msrr_pkg::FRAME_BYTES)
                        begin
                            phase_next = msrr_pkg::PH_IDLE;
                            res_valid  = 1'b1;
                            res_status = (crc_got == crc_reg) ? msrr_pkg::ST_OK
                                                              : msrr_pkg::ST_CRC;
                        end
                    end
                end
                msrr_pkg::KIND_TICK:
                begin
                    if (phase_reg != msrr_pkg::PH_IDLE)
                    begin
                        elapsed_next = elapsed_inc;
                        if (phase_reg == msrr_pkg::PH_WAIT)
                        begin
                            if (msrr_pkg::CMP_BITS'(elapsed_inc)
                                >= msrr_pkg::CMP_BITS'(reply_wait_reg))
                            begin
                                phase_next = msrr_pkg::PH_IDLE;
                                res_valid  = 1'b1;
                                res_status = msrr_pkg::ST_NORESP;
                            end
                        end
                        else if (msrr_pkg::CMP_BITS'(elapsed_inc)
                                 >= msrr_pkg::CMP_BITS'(char_gap_reg))
                        begin
                            phase_next = msrr_pkg::PH_IDLE;
                            res_valid  = 1'b1;
                            res_status = msrr_pkg::ST_INCOMPLETE;
                        end
                    end
                end
                default:
                begin
                    // Unused kind: ignored.
                end
            endcase
        end
    end

    // Result fields; the data fields are zero unless the frame checked out.
    always_comb
    begin
        res_data                    = '0;
        res_data.status             = res_status;
        res_data.reply_mode         = mode_reg;
        if (res_status == msrr_pkg::ST_OK)
        begin
            if (!mode_reg)
            begin
                res_data.light_hundredths = {payload_reg[2], payload_reg[3],
                                             payload_reg[0], payload_reg[1]};
            end
            else
            begin
                res_data.temperature_tenths = {payload_reg[0], payload_reg[1]};
                res_data.humidity_tenths    = {payload_reg[2], payload_reg[3]};
            end
        end
    end

    // Transaction state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= msrr_pkg::PH_IDLE;
            bytes_seen_reg <= '0;
            crc_reg        <= msrr_pkg::CRC_INIT;
            elapsed_reg    <= '0;
            mode_reg       <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_seen_reg <= bytes_seen_next;
            crc_reg        <= crc_next;
            elapsed_reg    <= elapsed_next;
            mode_reg       <= mode_next;
        end
    end

    // Payload bytes 3 to 8 of the frame.
    always_ff @(posedge clk)
    begin
        if (pay_we)
        begin
            payload_reg[pay_idx] <= in_data.rx_byte;
        end
    end

    // Output stage steering: result register first, skid when it is stalled.
    always_comb
    begin
        res_fire        = res_valid;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load_new    = 1'b0;
        out_load_skid   = 1'b0;
        skid_load       = 1'b0;
        if (out_valid_reg && !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_load_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (res_fire)
            begin
                out_load_new = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg)
        begin
            if (res_fire)
            begin
                out_load_new   = 1'b1;
                out_valid_next = 1'b1;
            end
        end
        else if (res_fire)
        begin
            skid_load       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load_skid)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (out_load_new)
        begin
            out_data_reg <= res_data;
        end
        if (skid_load)
        begin
            skid_data_reg <= res_data;
        end
    end

    // Checks.
    `ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_reg || out_valid_reg)
    `ASSERT_ALWAYS(a_count_in_frame,
                   phase_reg == msrr_pkg::PH_IDLE || bytes_seen_reg < msrr_pkg::FRAME_BYTES)
    `ASSERT_NEXT(a_byte_clears_timer,
                 in_accept && in_data.kind == msrr_pkg::KIND_BYTE
                     && phase_reg != msrr_pkg::PH_IDLE,
                 elapsed_reg == '0)

endmodule

// File: verif/modbus_sensor_reply_receiver_top_tb.sv
// Self-checking testbench for the Modbus sensor reply receiver, with directed and random traffic.
module modbus_sensor_reply_receiver_top_tb;

    // Kind code that the block must ignore, and the two read modes.
    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam logic       MODE_LIGHT   = 1'b0;
    localparam logic       MODE_CLIMATE = 1'b1;
    localparam int         RANDOM_BEATS = 1300;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    msrr_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_stall;
    msrr_pkg::out_t out_data;
    logic           cfg_we;
    logic           cfg_index;
    logic [15:0]    cfg_data;

    modbus_sensor_reply_receiver_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Replies still owed by the block, oldest first.
    msrr_pkg::out_t pending_replies[$];

    // Mirror of the receiver's state and its two timeout registers.
    msrr_pkg::phase_t                rx_phase;
    logic [3:0]                      rx_count;
    logic [15:0]                     rx_crc;
    logic [7:0]                      rx_payload [msrr_pkg::PAYLOAD_DEPTH];
    logic [msrr_pkg::TIMER_BITS-1:0] rx_elapsed;
    logic                            rx_mode;
    logic [15:0]                     gap_limit;
    logic [15:0]                     wait_limit;

    int error_count = 0;
    int live_beats  = 0;
    int burst_left  = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #50000000;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    // CRC-16/MODBUS update over one byte, LSB first.
    function automatic logic [15:0] crc16_modbus_fold(input logic [15:0] crc,
                                                      input logic [7:0] data);
        logic [15:0] acc;
        acc = crc ^ {8'h00, data};
        repeat (8)
        begin
            acc = acc[0] ? ((acc >> 1) ^ msrr_pkg::CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    // End the open transaction and queue the reply it owes.
    function automatic void close_reply(input logic [1:0] status);
        msrr_pkg::out_t r;
        r = '0;
        r.status     = status;
        r.reply_mode = rx_mode;
        if (status == msrr_pkg::ST_OK)
        begin
            if (rx_mode == MODE_LIGHT)
            begin
                r.light_hundredths = {rx_payload[2], rx_payload[3],
                                      rx_payload[0], rx_payload[1]};
            end
            else
            begin
                r.temperature_tenths = {rx_payload[0], rx_payload[1]};
                r.humidity_tenths    = {rx_payload[2], rx_payload[3]};
            end
        end
        pending_replies.push_back(r);
        rx_phase = msrr_pkg::PH_IDLE;
    endfunction

    // Advance the mirrored receiver by one accepted beat.
    function automatic void absorb_beat(input msrr_pkg::in_t b);
        logic [3:0] n;
        if (b.kind == msrr_pkg::KIND_START)
        begin
            rx_phase   = msrr_pkg::PH_WAIT;
            rx_count   = '0;
            rx_crc     = msrr_pkg::CRC_INIT;
            rx_elapsed = '0;
            rx_mode    = b.read_mode;
        end
        else if (rx_phase != msrr_pkg::PH_IDLE && b.kind == msrr_pkg::KIND_BYTE)
        begin
            n = rx_count;
            if (n < msrr_pkg::CRC_BYTES)
            begin
                rx_crc = crc16_modbus_fold(rx_crc, b.rx_byte);
            end
            if (n >= msrr_pkg::PAYLOAD_FIRST)
            begin
                rx_payload[3'(n - msrr_pkg::PAYLOAD_FIRST)] = b.rx_byte;
            end
            rx_count   = n + 4'd1;
            rx_elapsed = '0;
            rx_phase   = msrr_pkg::PH_RECV;
            if (rx_count >= msrr_pkg::FRAME_BYTES)
            begin
                close_reply(({rx_payload[5], rx_payload[4]} == rx_crc) ? msrr_pkg::ST_OK
                                                                       : msrr_pkg::ST_CRC);
            end
        end
        else if (rx_phase != msrr_pkg::PH_IDLE && b.kind == msrr_pkg::KIND_TICK)
        begin
            // The elapsed counter saturates rather than wrapping.
            if (rx_elapsed != '1)
            begin
                rx_elapsed++;
            end
            if (rx_phase == msrr_pkg::PH_WAIT)
            begin
                if (rx_elapsed >= wait_limit)
                begin
                    close_reply(msrr_pkg::ST_NORESP);
                end
            end
            else if (rx_elapsed >= gap_limit)
            begin
                close_reply(msrr_pkg::ST_INCOMPLETE);
            end
        end
    endfunction

    function automatic msrr_pkg::in_t make_beat(input logic [1:0] kind, input logic [7:0] data,
                                                input logic mode);
        msrr_pkg::in_t b;
        b.kind      = kind;
        b.rx_byte   = data;
        b.read_mode = mode;
        return b;
    endfunction

    // A tick beat with random filler in the unused fields.
    function automatic msrr_pkg::in_t tick_beat();
        return make_beat(msrr_pkg::KIND_TICK, 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
    endfunction

    // Send one beat; the sender may idle between bursts of random length.
    task automatic send_beat(input msrr_pkg::in_t b);
        int idle;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (idle > 0)
            begin
                in_valid <= 1'b0;
                repeat (idle) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (in_stall);
        if (b.kind == msrr_pkg::KIND_START
            || (rx_phase != msrr_pkg::PH_IDLE && b.kind != KIND_UNUSED))
        begin
            live_beats++;
        end
        absorb_beat(b);
    endtask

    // Stop sending and wait until every owed reply has come back.
    task automatic settle_block;
        in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_ticks_until_idle;
        while (rx_phase != msrr_pkg::PH_IDLE)
        begin
            send_beat(tick_beat());
        end
    endtask

    // Reprogram both timeouts once the block has nothing in flight.
    task automatic set_timeouts(input logic [15:0] gap_ticks, input logic [15:0] wait_ticks);
        run_ticks_until_idle();
        settle_block();
        cfg_we    <= 1'b1;
        cfg_index <= msrr_pkg::CFG_CHAR_GAP;
        cfg_data  <= gap_ticks;
        @(posedge clk);
        cfg_index <= msrr_pkg::CFG_REPLY_WAIT;
        cfg_data  <= wait_ticks;
        @(posedge clk);
        cfg_we     <= 1'b0;
        gap_limit  = gap_ticks;
        wait_limit = wait_ticks;
    endtask

    // Start a transaction, send the first n_bytes of a reply frame with ticks short of
    // the timeouts. With tight set and a timeout up to 64, each wait is one tick short.
    task automatic send_frame(input logic mode, input logic [31:0] data, input int n_bytes,
                              input bit corrupt, input bit tight);
        logic [7:0]  frm [9];
        logic [15:0] crc;
        int          limit;
        int          ticks;
        int          hit;
        frm[0] = 8'($urandom_range(0, 255));
        frm[1] = 8'($urandom_range(0, 255));
        frm[2] = 8'($urandom_range(0, 255));
        frm[3] = data[31:24];
        frm[4] = data[23:16];
        frm[5] = data[15:8];
        frm[6] = data[7:0];
        crc = msrr_pkg::CRC_INIT;
        for (int i = 0; i < 7; i++)
        begin
            crc = crc16_modbus_fold(crc, frm[i]);
        end
        frm[7] = crc[7:0];
        frm[8] = crc[15:8];
        if (corrupt)
        begin
            hit = $urandom_range(0, 8);
            frm[hit] = frm[hit] ^ 8'($urandom_range(1, 255));
        end
        send_beat(make_beat(msrr_pkg::KIND_START, 8'($urandom_range(0, 255)), mode));
        for (int i = 0; i < n_bytes; i++)
        begin
            limit = (i == 0) ? int'(wait_limit) : int'(gap_limit);
            if (tight && limit <= 64)
            begin
                ticks = limit - 1;
            end
            else
            begin
                ticks = $urandom_range(0, (limit - 1 < 6) ? limit - 1 : 6);
            end
            repeat (ticks)
            begin
                send_beat(tick_beat());
            end
            send_beat(make_beat(msrr_pkg::KIND_BYTE, frm[i], 1'($urandom_range(0, 1))));
        end
    endtask

    // Bytes, ticks and unused kinds while idle must produce nothing.
    task automatic test_idle_items;
        send_beat(make_beat(msrr_pkg::KIND_BYTE, 8'h00, MODE_LIGHT));
        send_beat(make_beat(msrr_pkg::KIND_BYTE, 8'hFF, MODE_CLIMATE));
        send_beat(make_beat(msrr_pkg::KIND_TICK, 8'hA5, MODE_LIGHT));
        send_beat(make_beat(KIND_UNUSED, 8'hFF, MODE_CLIMATE));
    endtask

    // Timeouts at their reset values are long: short waits never expire, and a new
    // start drops the open frame without a reply.
    task automatic test_reset_timeouts;
        send_frame(MODE_LIGHT, 32'h0, 3, 1'b0, 1'b0);
        repeat (40) send_beat(tick_beat());
        send_frame(MODE_CLIMATE, 32'h0, 0, 1'b0, 1'b0);
        repeat (40) send_beat(tick_beat());
        send_frame(MODE_LIGHT, $urandom, 9, 1'b0, 1'b0);
    endtask

    // Complete frames with extreme payloads in both modes.
    task automatic test_good_frames;
        send_frame(MODE_LIGHT, 32'hFFFF_FFFF, 9, 1'b0, 1'b0);
        send_frame(MODE_CLIMATE, 32'h8000_0000, 9, 1'b0, 1'b0);
        send_frame(MODE_LIGHT, 32'h0000_0000, 9, 1'b0, 1'b0);
        send_frame(MODE_CLIMATE, 32'h7FFF_FFFF, 9, 1'b0, 1'b0);
    endtask

    task automatic test_crc_mismatch;
        send_frame(MODE_CLIMATE, $urandom, 9, 1'b1, 1'b0);
        send_frame(MODE_LIGHT, $urandom, 9, 1'b1, 1'b0);
    endtask

    // An unused kind inside a frame, then a new start that drops the frame.
    task automatic test_restart_and_unused;
        send_frame(MODE_LIGHT, $urandom, 5, 1'b0, 1'b0);
        send_beat(make_beat(KIND_UNUSED, 8'h5A, MODE_CLIMATE));
        send_frame(MODE_CLIMATE, $urandom, 9, 1'b0, 1'b0);
    endtask

    // Smallest timeouts, and waits that stop one tick short of expiry.
    task automatic test_timeout_edges;
        set_timeouts(16'd1, 16'd1);
        send_frame(MODE_CLIMATE, 32'h0, 0, 1'b0, 1'b0);
        run_ticks_until_idle();
        send_frame(MODE_LIGHT, 32'h0, 1, 1'b0, 1'b0);
        run_ticks_until_idle();
        send_frame(MODE_LIGHT, $urandom, 9, 1'b0, 1'b0);
        set_timeouts(16'd3, 16'd5);
        send_frame(MODE_CLIMATE, $urandom, 9, 1'b0, 1'b1);
        send_frame(MODE_LIGHT, $urandom, 4, 1'b0, 1'b1);
        run_ticks_until_idle();
    endtask

    // Largest timeouts: long waits inside a frame must not expire.
    task automatic test_long_timeouts;
        set_timeouts(16'hFFFF, 16'hFFFF);
        send_frame(MODE_LIGHT, 32'h0, 0, 1'b0, 1'b0);
        repeat (40) send_beat(tick_beat());
        send_frame(MODE_CLIMATE, 32'h0, 2, 1'b0, 1'b0);
        repeat (40) send_beat(tick_beat());
        send_frame(MODE_CLIMATE, $urandom, 9, 1'b0, 1'b0);
    endtask

    // Mostly well-formed transactions, with broken frames, restarts and noise mixed in.
    task automatic test_random_traffic;
        int start_count;
        int next_cfg;
        int scenario;
        start_count = live_beats;
        next_cfg    = live_beats;
        while (live_beats - start_count < RANDOM_BEATS)
        begin
            if (live_beats >= next_cfg)
            begin
                next_cfg = live_beats + $urandom_range(200, 400);
                if ($urandom_range(0, 3) == 0)
                begin
                    set_timeouts(16'd1, 16'd1);
                end
                else
                begin
                    set_timeouts(16'($urandom_range(1, 12)), 16'($urandom_range(1, 16)));
                end
            end
            scenario = $urandom_range(0, 99);
            if (scenario < 50)
            begin
                send_frame(1'($urandom_range(0, 1)), $urandom, 9, 1'b0,
                           $urandom_range(0, 3) == 0);
            end
            else if (scenario < 62)
            begin
                send_frame(1'($urandom_range(0, 1)), $urandom, 9, 1'b1,
                           $urandom_range(0, 3) == 0);
            end
            else if (scenario < 74)
            begin
                send_frame(1'($urandom_range(0, 1)), $urandom, $urandom_range(1, 8), 1'b0,
                           $urandom_range(0, 3) == 0);
                run_ticks_until_idle();
            end
            else if (scenario < 82)
            begin
                send_frame(1'($urandom_range(0, 1)), $urandom, 0, 1'b0, 1'b0);
                run_ticks_until_idle();
            end
            else if (scenario < 88)
            begin
                send_frame(1'($urandom_range(0, 1)), $urandom, $urandom_range(1, 8), 1'b0,
                           1'b0);
                send_frame(1'($urandom_range(0, 1)), $urandom, 9, 1'b0, 1'b0);
            end
            else if (scenario < 97)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    send_beat(make_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                        1'($urandom_range(0, 1))));
                end
            end
            else
            begin
                settle_block();
            end
        end
        run_ticks_until_idle();
    endtask

    // The receiver stalls in one of four styles, each chosen anew at random.
    initial
    begin
        int stall_left;
        int stall_style;
        stall_left  = 0;
        stall_style = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0)
            begin
                stall_left  = $urandom_range(20, 200);
                stall_style = $urandom_range(0, 3);
            end
            stall_left--;
            case (stall_style)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= 1'($urandom_range(0, 1));
                default: out_stall <= ((stall_left % 8) < 5);
            endcase
        end
    end

    // Compare each accepted reply beat with the oldest owed reply.
    always @(posedge clk)
    begin : check_replies
        msrr_pkg::out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                report_mismatch($sformatf("reply with none owed, status %0d", out_data.status));
            end
            else
            begin
                want = pending_replies.pop_front();
                if (out_data.status !== want.status)
                begin
                    report_mismatch($sformatf("status got %0d, expected %0d",
                                              out_data.status, want.status));
                end
                if (out_data.light_hundredths !== want.light_hundredths)
                begin
                    report_mismatch($sformatf("light got %h, expected %h",
                                              out_data.light_hundredths, want.light_hundredths));
                end
                if (out_data.temperature_tenths !== want.temperature_tenths)
                begin
                    report_mismatch($sformatf("temperature got %h, expected %h",
                                              out_data.temperature_tenths,
                                              want.temperature_tenths));
                end
                if (out_data.humidity_tenths !== want.humidity_tenths)
                begin
                    report_mismatch($sformatf("humidity got %h, expected %h",
                                              out_data.humidity_tenths, want.humidity_tenths));
                end
                if (out_data.reply_mode !== want.reply_mode)
                begin
                    report_mismatch($sformatf("mode got %0d, expected %0d",
                                              out_data.reply_mode, want.reply_mode));
                end
            end
        end
    end

    // Reset, run each test in turn, then wait for the last replies.
    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= msrr_pkg::CFG_CHAR_GAP;
        cfg_data  <= '0;
        rx_phase   = msrr_pkg::PH_IDLE;
        rx_count   = '0;
        rx_crc     = msrr_pkg::CRC_INIT;
        rx_elapsed = '0;
        rx_mode    = MODE_LIGHT;
        gap_limit  = msrr_pkg::CHAR_GAP_RESET;
        wait_limit = msrr_pkg::REPLY_WAIT_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_idle_items();
        test_reset_timeouts();
        test_good_frames();
        test_crc_mismatch();
        test_restart_and_unused();
        test_timeout_edges();
        test_long_timeouts();
        test_random_traffic();

        settle_block();
        if (error_count == 0 && pending_replies.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
